// ===== design/mmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared constants and codes for the mailbox message queue.
// ----------------------------------------------------------------------------
package mmq_pkg;

   // fixed field widths of the item ports
   localparam int ID_BITS      = 6;
   localparam int ID_RANGE     = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int STATUS_BITS  = 2;

   // parameter defaults
   localparam int DEF_MSG_SLOTS  = 256;
   localparam int DEF_THREADS    = 64;
   localparam int DEF_VALUE_BITS = 32;

   // opcodes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_GET = 1'b1;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 2'd0,
      ST_POOL_EMPTY = 2'd1,
      ST_NO_SENDER  = 2'd2,
      ST_NO_MATCH   = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ===== design/mailbox_message_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mailbox_message_queue
// Mailbox engine: a pool of message slots on a free list and a linked FIFO
// of pending messages per destination thread, all held in block memories.
// ----------------------------------------------------------------------------
// One item is worked at a time, each step being a read, modify and write of
// the queue memory or the slot memory. An add that succeeds fills a slot and
// hooks it onto its destination queue, with one more step to link the old
// tail when the queue was not empty; an add that fails goes straight to
// completion. A get reads the queue entry and, if the queue is not empty,
// walks down it, reading one slot per cycle from the slot memory, until a
// message matches or the tail has been examined; a get without a sender
// filter takes the head message, and a matched slot goes back to the free
// list. After reset the block clears the queue memory before it accepts its
// first item. A finished result sits in an output register, so the next item
// is taken while it waits; a further result is held in the completion step
// until that register is free.
module mailbox_message_queue #(
   parameter int MSG_SLOTS  = mmq_pkg::DEF_MSG_SLOTS,
   parameter int THREADS    = mmq_pkg::DEF_THREADS,
   parameter int VALUE_BITS = mmq_pkg::DEF_VALUE_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic                               req_sender_given,
   input  wire logic [mmq_pkg::ID_BITS-1:0]        req_sender_id,
   input  wire logic [mmq_pkg::ID_BITS-1:0]        req_dest_id,
   input  wire logic [mmq_pkg::PAYLOAD_BITS-1:0]   req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [mmq_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [mmq_pkg::PAYLOAD_BITS-1:0]        rsp_got_value,
   output logic [mmq_pkg::ID_BITS-1:0]             rsp_got_sender
);
   import mmq_pkg::*;

   localparam int IW = $clog2(MSG_SLOTS);
   localparam int TW = $clog2(THREADS);
   localparam int DW = (VALUE_BITS < PAYLOAD_BITS) ? VALUE_BITS : PAYLOAD_BITS;

   typedef struct packed {
      logic [IW-1:0] head;
      logic [IW-1:0] tail;
      logic          nonempty;
   } qent_type;

   typedef enum logic [8:0] {
      S_CLR  = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_RD   = 9'b000000100,
      S_ADD1 = 9'b000001000,
      S_ADD2 = 9'b000010000,
      S_G0   = 9'b000100000,
      S_G1   = 9'b001000000,
      S_G2   = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   // memories
   qent_type          queue_mem   [THREADS];
   logic [IW-1:0]     slot_next   [MSG_SLOTS];
   logic [ID_BITS-1:0] slot_sender [MSG_SLOTS];
   logic [DW-1:0]     slot_value  [MSG_SLOTS];

   // registers
   state_type          state_ff, state_in;
   logic [TW-1:0]      clr_ff, clr_in;
   logic               op_ff, op_in;
   logic               given_ff, given_in;
   logic [ID_BITS-1:0] sid_ff, sid_in;
   logic [TW-1:0]      dest_ff, dest_in;
   logic [DW-1:0]      pay_ff, pay_in;
   logic [IW-1:0]      free_head_ff, free_head_in;
   logic [IW:0]        free_count_ff, free_count_in;
   logic [IW:0]        wm_ff, wm_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [IW-1:0]      prev_ff, prev_in;
   logic               has_prev_ff, has_prev_in;
   qent_type           q_ff, q_in;
   status_type         res_status_ff, res_status_in;
   logic [DW-1:0]      res_value_ff, res_value_in;
   logic [ID_BITS-1:0] res_sender_ff, res_sender_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [ID_BITS-1:0] rsp_sender_ff, rsp_sender_in;

   // memory read data
   qent_type           q_rd_ff;
   logic [IW-1:0]      s_rd_next_ff;
   logic [ID_BITS-1:0] s_rd_sender_ff;
   logic [DW-1:0]      s_rd_value_ff;

   // memory controls
   logic               q_we;
   logic [TW-1:0]      q_waddr, q_raddr;
   qent_type           q_wdata;
   logic [IW-1:0]      s_raddr, s_waddr;
   logic               s_we_next, s_we_data;
   logic [IW-1:0]      s_wnext;

   // destination index folded into the thread range
   logic [TW-1:0] dmod_tbl [ID_RANGE];
   genvar g;
   for (g = 0; g < ID_RANGE; g++) begin : g_dmod
      assign dmod_tbl[g] = TW'(g % THREADS);
   end

   logic          match;
   logic [IW-1:0] fh_inc;
   logic [IW-1:0] fh_next;
   logic          out_free;

   // link of the free-list head; slots never allocated still chain in order
   assign fh_inc  = (free_head_ff == IW'(MSG_SLOTS - 1)) ? '0 : free_head_ff + 1'b1;
   assign fh_next = ({1'b0, free_head_ff} >= wm_ff) ? fh_inc : s_rd_next_ff;
   assign match   = !given_ff || (s_rd_sender_ff == sid_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      given_in      = given_ff;
      sid_in        = sid_ff;
      dest_in       = dest_ff;
      pay_in        = pay_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      wm_in         = wm_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      has_prev_in   = has_prev_ff;
      q_in          = q_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_sender_in = res_sender_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sender_in = rsp_sender_ff;
      req_ready     = 1'b0;
      q_we          = 1'b0;
      q_waddr       = dest_ff;
      q_wdata       = q_ff;
      q_raddr       = dest_ff;
      s_raddr       = free_head_ff;
      s_waddr       = cur_ff;
      s_we_next     = 1'b0;
      s_we_data     = 1'b0;
      s_wnext       = free_head_ff;
      unique case (state_ff)
         S_CLR: begin
            q_we    = 1'b1;
            q_waddr = clr_ff;
            q_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == TW'(THREADS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = req_opcode;
               given_in      = req_sender_given;
               sid_in        = req_sender_id;
               dest_in       = dmod_tbl[req_dest_id];
               pay_in        = DW'(req_payload);
               res_status_in = ST_OK;
               res_value_in  = '0;
               res_sender_in = '0;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            // queue entry and free-list head link are read here
            if (op_ff == OP_ADD) begin
               priority if (free_count_ff == '0) begin
                  res_status_in = ST_POOL_EMPTY;
                  state_in      = S_DONE;
               end else if (!given_ff) begin
                  res_status_in = ST_NO_SENDER;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_ADD1;
               end
            end else begin
               state_in = S_G0;
            end
         end
         S_ADD1: begin
            // fill the slot, pop the free list, hook the slot onto the queue
            s_we_data     = 1'b1;
            s_waddr       = free_head_ff;
            cur_in        = free_head_ff;
            free_head_in  = fh_next;
            free_count_in = free_count_ff - 1'b1;
            if (wm_ff == {1'b0, free_head_ff}) begin
               wm_in = wm_ff + 1'b1;
            end
            q_in    = q_rd_ff;
            q_we    = 1'b1;
            q_wdata.nonempty = 1'b1;
            q_wdata.tail     = free_head_ff;
            q_wdata.head     = q_rd_ff.nonempty ? q_rd_ff.head : free_head_ff;
            state_in = q_rd_ff.nonempty ? S_ADD2 : S_DONE;
         end
         S_ADD2: begin
            // link the old tail to the new slot
            s_we_next = 1'b1;
            s_waddr   = q_ff.tail;
            s_wnext   = cur_ff;
            state_in  = S_DONE;
         end
         S_G0: begin
            q_in = q_rd_ff;
            if (!q_rd_ff.nonempty) begin
               res_status_in = ST_NO_MATCH;
               state_in      = S_DONE;
            end else begin
               s_raddr     = q_rd_ff.head;
               cur_in      = q_rd_ff.head;
               has_prev_in = 1'b0;
               state_in    = S_G1;
            end
         end
         S_G1: begin
            // walk the queue one slot a cycle
            s_raddr = s_rd_next_ff;
            priority if (match) begin
               res_value_in  = s_rd_value_ff;
               res_sender_in = s_rd_sender_ff;
               state_in      = S_G2;
               priority if (cur_ff == q_ff.tail) begin
                  q_we = 1'b1;
                  if (has_prev_ff) begin
                     q_wdata.tail = prev_ff;
                  end else begin
                     q_wdata.nonempty = 1'b0;
                  end
               end else if (has_prev_ff) begin
                  s_we_next = 1'b1;
                  s_waddr   = prev_ff;
                  s_wnext   = s_rd_next_ff;
               end else begin
                  q_we         = 1'b1;
                  q_wdata.head = s_rd_next_ff;
               end
            end else if (cur_ff == q_ff.tail) begin
               res_status_in = ST_NO_MATCH;
               state_in      = S_DONE;
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = s_rd_next_ff;
            end
         end
         S_G2: begin
            // return the slot to the front of the free list
            s_we_next     = 1'b1;
            s_waddr       = cur_ff;
            s_wnext       = free_head_ff;
            free_head_in  = cur_ff;
            free_count_in = free_count_ff + 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = PAYLOAD_BITS'(res_value_ff);
               rsp_sender_in = res_sender_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         free_head_ff  <= '0;
         free_count_ff <= (IW + 1)'(MSG_SLOTS);
         wm_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         wm_ff         <= wm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      given_ff      <= given_in;
      sid_ff        <= sid_in;
      dest_ff       <= dest_in;
      pay_ff        <= pay_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      q_ff          <= q_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_sender_ff <= res_sender_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sender_ff <= rsp_sender_in;
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= queue_mem[q_raddr];
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (s_we_next) begin
         slot_next[s_waddr] <= s_wnext;
      end
      if (s_we_data) begin
         slot_sender[s_waddr] <= sid_ff;
         slot_value[s_waddr]  <= pay_ff;
      end
      s_rd_next_ff   <= slot_next[s_raddr];
      s_rd_sender_ff <= slot_sender[s_raddr];
      s_rd_value_ff  <= slot_value[s_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_got_value  = rsp_value_ff;
   assign rsp_got_sender = rsp_sender_ff;

`ifndef SYNTHESIS
   // pool accounting stays within the slot count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= (IW + 1)'(MSG_SLOTS))
      else $error("free count beyond pool size");

   // fresh slots are handed out at most once each
   a_wm_range: assert property (@(posedge clock) disable iff (reset)
      wm_ff <= (IW + 1)'(MSG_SLOTS))
      else $error("allocation mark beyond pool size");

   // a result appears only out of the completion step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   // failed items report no value or sender
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0)
         && (rsp_sender_ff == '0))
      else $error("failed item carries data");
`endif

endmodule
`default_nettype wire
